// File: rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/bsa_pkg.sv
package bsa_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int WORD_W          = 64;
    localparam int BIT_W           = $clog2(WORD_W);

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 13;
    localparam int CAP_W    = 13;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 56;

    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic take;
        logic rd;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

// File: rtl/bsa_ctrl.sv
module bsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  bsa_pkg::t_sts i_sts,
    output logic          o_s_ready,
    output bsa_pkg::t_cmd o_cmd
);
    import bsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_ready = 1'b0;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.take = i_s_valid;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = !i_sts.out_busy;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/bsa_dp.sv
module bsa_dp #(
    parameter int TABLE_DEPTH = bsa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bsa_pkg::t_cmd                  i_cmd,
    output bsa_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [bsa_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  logic [bsa_pkg::FUNC_W-1:0]     i_func,
    input  logic [bsa_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [bsa_pkg::SLOT_W-1:0]     o_granted_slot,
    output logic [bsa_pkg::STATUS_W-1:0]   o_status,
    output logic [bsa_pkg::COUNT_W-1:0]    o_free_slots,
    output logic [bsa_pkg::COUNT_W-1:0]    o_active_slots,
    output logic [bsa_pkg::COUNT_W-1:0]    o_used_size
);
    import bsa_pkg::*;

    localparam int N_WORDS = (TABLE_DEPTH + WORD_W - 1) / WORD_W;
    localparam int WA_W    = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    logic [WORD_W-1:0]   mem [N_WORDS];

    logic [FUNC_W-1:0]   r_func;
    logic [SLOT_W-1:0]   r_idx;
    logic [WA_W-1:0]     r_wa;
    logic                r_any;
    logic                r_wv;
    logic [WORD_W-1:0]   r_rdata;
    logic [N_WORDS-1:0]  r_sum;
    logic [N_WORDS-1:0]  n_sum;
    logic [CNT_W-1:0]    r_size;
    logic [CNT_W-1:0]    n_size;
    logic [CNT_W-1:0]    r_free;
    logic [CNT_W-1:0]    n_free;
    logic [CAP_W-1:0]    r_cap;

    logic                r_ovalid;
    logic [SLOT_W-1:0]   r_oslot;
    logic [STATUS_W-1:0] r_ostatus;
    logic [COUNT_W-1:0]  r_ofree;
    logic [COUNT_W-1:0]  r_oactive;
    logic [COUNT_W-1:0]  r_oused;

    logic [WA_W-1:0]     first_wa;
    logic [WA_W-1:0]     rd_wa;
    logic [WORD_W-1:0]   word;
    logic [BIT_W-1:0]    low_bit;
    logic [BIT_W-1:0]    bit_sel;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   wdata;
    logic                we;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [31:0]         limit;

    // Word search over summary bits
    always_comb begin
        first_wa = '0;
        for (int i = N_WORDS - 1; i >= 0; i--) begin
            if (r_sum[i]) begin
                first_wa = WA_W'(i);
            end
        end
        rd_wa = (r_func == FN_RELEASE) ? WA_W'(32'(r_idx) >> BIT_W) : first_wa;
    end

    always_comb begin
        word    = r_wv ? r_rdata : '0;
        low_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (word[i]) begin
                low_bit = BIT_W'(i);
            end
        end
        bit_sel = (r_func == FN_RELEASE) ? r_idx[BIT_W-1:0] : low_bit;
        mask    = WORD_W'(1) << bit_sel;
    end

    always_comb begin
        limit = (r_cap == '0 || 32'(r_cap) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                               : 32'(r_cap);
    end

    always_comb begin
        we     = 1'b0;
        wdata  = word;
        n_sum  = r_sum;
        n_size = r_size;
        n_free = r_free;
        slot   = '0;
        status = ST_DONE;
        case (r_func)
            FN_RELEASE: begin
                slot = r_idx;
                if (32'(r_idx) < 32'(r_size)) begin
                    if (!word[bit_sel]) begin
                        we          = 1'b1;
                        wdata       = word | mask;
                        n_sum[r_wa] = 1'b1;
                        n_free      = r_free + CNT_W'(1);
                    end
                end else begin
                    status = ST_BAD;
                end
            end
            FN_ALLOC: begin
                if (r_any) begin
                    we          = 1'b1;
                    wdata       = word & ~mask;
                    n_sum[r_wa] = |(word & ~mask);
                    n_free      = r_free - CNT_W'(1);
                    slot        = SLOT_W'((32'(r_wa) << BIT_W) | 32'(low_bit));
                    status      = ST_REUSED;
                end else if (32'(r_size) < limit) begin
                    slot   = SLOT_W'(r_size);
                    n_size = r_size + CNT_W'(1);
                    status = ST_APPENDED;
                end else begin
                    status = ST_FULL;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_wa];
        end
        if (i_cmd.exec && we) begin
            mem[r_wa] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func <= i_func;
            r_idx  <= i_slot_index;
        end
        if (i_cmd.rd) begin
            r_wa  <= rd_wa;
            r_wv  <= r_sum[rd_wa];
            r_any <= |r_sum;
        end
        if (i_cmd.exec) begin
            r_oslot   <= slot;
            r_ostatus <= status;
            r_ofree   <= COUNT_W'(n_free);
            r_oactive <= COUNT_W'(n_size - n_free);
            r_oused   <= COUNT_W'(n_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_size   <= '0;
            r_free   <= '0;
            r_cap    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_sum    <= n_sum;
                r_size   <= n_size;
                r_free   <= n_free;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_ovalid && !i_out_ready;

    assign o_out_valid    = r_ovalid;
    assign o_granted_slot = r_oslot;
    assign o_status       = r_ostatus;
    assign o_free_slots   = r_ofree;
    assign o_active_slots = r_oactive;
    assign o_used_size    = r_oused;

endmodule

// File: rtl/bitmap_slot_allocator.sv
// Channel   Direction  tdata (low bit up)                            tuser
// s_*       in         slot_index[11:0], zero[15:12]                 func[1:0]
// m_*       out        granted_slot[11:0], free_slots[24:12],        status[2:0]
//                      active_slots[37:25], used_size[50:38], zero[55:51]
// cfg       in         i_cfg_wdata = capacity, written when i_cfg_we
//
// Each word steps through accept, bitmap word read, then update and result load.
// The free bitmap sits in a 64-bit-wide memory, one read and at most one write per word;
// a flip-flop summary bit per memory word marks non-empty words and steers the search.
// Reset (i_rst_n low, synchronous) clears the summary bits, so no clearing pass runs.
// A result waits in the output register; a stalled m side holds the update stage.
module bitmap_slot_allocator
#(
    parameter int TABLE_DEPTH = bsa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsa_pkg::S_DATA_W-1:0]    s_tdata,  // slot_index
    input  logic [bsa_pkg::FUNC_W-1:0]      s_tuser,  // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsa_pkg::M_DATA_W-1:0]    m_tdata,  // granted_slot, free, active, used
    output logic [bsa_pkg::STATUS_W-1:0]    m_tuser,  // status
    input  logic                            i_cfg_we,
    input  logic [bsa_pkg::CAP_W-1:0]       i_cfg_wdata
);
    import bsa_pkg::*;

`include "assert_macros.svh"

    t_cmd                cmd;
    t_sts                sts;
    logic [SLOT_W-1:0]   granted_slot;
    logic [COUNT_W-1:0]  free_slots;
    logic [COUNT_W-1:0]  active_slots;
    logic [COUNT_W-1:0]  used_size;

    bsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_sts     (sts),
        .o_s_ready (s_tready),
        .o_cmd     (cmd)
    );

    bsa_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (s_tuser),
        .i_slot_index   (s_tdata[SLOT_W-1:0]),
        .i_out_ready    (m_tready),
        .o_out_valid    (m_tvalid),
        .o_granted_slot (granted_slot),
        .o_status       (m_tuser),
        .o_free_slots   (free_slots),
        .o_active_slots (active_slots),
        .o_used_size    (used_size)
    );

    assign m_tdata = {(M_DATA_W - SLOT_W - 3 * COUNT_W)'(0),
                      used_size, active_slots, free_slots, granted_slot};

    `ASSERT_ALWAYS(a_reset_out_idle, !i_rst_n |=> !m_tvalid, "result valid after reset")
    `ASSERT_RST(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "second word taken")
    `ASSERT_RST(a_free_le_used, m_tvalid |-> (free_slots <= used_size), "free above used")
    `ASSERT_RST(a_reuse_in_range, (m_tvalid && m_tuser == ST_REUSED) |-> (COUNT_W'(granted_slot) < used_size), "reused slot out of range")
    `ASSERT_RST(a_append_at_top, (m_tvalid && m_tuser == ST_APPENDED) |-> (COUNT_W'(granted_slot) + COUNT_W'(1) == used_size), "append not at top")

endmodule

// File: sim/bitmap_slot_allocator_tb.sv
module bitmap_slot_allocator_tb;
    import bsa_pkg::*;

    localparam int          DEPTH      = TABLE_DEPTH_DEF;
    localparam int          PHASES     = 10;
    localparam int          PHASE_LEN  = 163;
    localparam int          HOLD_LEN   = 400;
    localparam int unsigned RUN_LIMIT  = 5_000_000;
    localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  free_cnt;
        logic [COUNT_W-1:0]  active_cnt;
        logic [COUNT_W-1:0]  used_cnt;
    } t_grant;

    typedef struct {
        bit                is_cfg;
        logic [CAP_W-1:0]  cap;
        logic [FUNC_W-1:0] fn;
        logic [SLOT_W-1:0] idx;
        bit                typed;
        t_grant            ex;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                i_cfg_we;
    logic [CAP_W-1:0]    i_cfg_wdata;

    bit     free_bits [DEPTH];
    int     size_mark;
    int     free_tally;
    int     cap_reg;
    t_grant awaited_grants [$];
    int     mismatch_count;

    bit     word_typed;
    t_grant word_ex;
    bit     idle_on;
    bit     long_hold_req;
    bit     rx_holding;

    t_row   plan [$];

    bitmap_slot_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_grant grant(input int slot, input logic [STATUS_W-1:0] st,
                                     input int fr, input int act, input int used);
        t_grant g;
        g.slot       = SLOT_W'(slot);
        g.status     = st;
        g.free_cnt   = COUNT_W'(fr);
        g.active_cnt = COUNT_W'(act);
        g.used_cnt   = COUNT_W'(used);
        return g;
    endfunction

    function automatic t_row word_row(input logic [FUNC_W-1:0] fn, input int idx);
        t_row r;
        r.is_cfg = 1'b0;
        r.cap    = '0;
        r.fn     = fn;
        r.idx    = SLOT_W'(idx);
        r.typed  = 1'b0;
        r.ex     = '0;
        return r;
    endfunction

    function automatic t_row typed_row(input logic [FUNC_W-1:0] fn, input int idx,
                                       input t_grant ex);
        t_row r;
        r       = word_row(fn, idx);
        r.typed = 1'b1;
        r.ex    = ex;
        return r;
    endfunction

    function automatic t_row cfg_row(input int cap);
        t_row r;
        r        = word_row(FN_QUERY, 0);
        r.is_cfg = 1'b1;
        r.cap    = CAP_W'(cap);
        return r;
    endfunction

    function automatic void add_row(input t_row r);
        plan = {plan, r};
    endfunction

    function automatic t_grant apply_request(input logic [FUNC_W-1:0] fn,
                                             input logic [SLOT_W-1:0] idx);
        t_grant g;
        int     lim;
        int     pick;
        g.slot   = '0;
        g.status = ST_DONE;
        lim = (cap_reg == 0 || cap_reg > DEPTH) ? DEPTH : cap_reg;
        if (fn == FN_RELEASE) begin
            g.slot = idx;
            if (int'(idx) < size_mark) begin
                if (!free_bits[idx]) begin
                    free_bits[idx] = 1'b1;
                    free_tally++;
                end
            end else begin
                g.status = ST_BAD;
            end
        end else if (fn == FN_ALLOC) begin
            pick = size_mark;
            for (int i = 0; i < size_mark; i++) begin
                if (free_bits[i]) begin
                    pick = i;
                    break;
                end
            end
            if (pick < size_mark) begin
                free_bits[pick] = 1'b0;
                free_tally--;
                g.slot   = SLOT_W'(pick);
                g.status = ST_REUSED;
            end else if (size_mark < lim) begin
                free_bits[size_mark] = 1'b0;
                g.slot   = SLOT_W'(size_mark);
                g.status = ST_APPENDED;
                size_mark++;
            end else begin
                g.status = ST_FULL;
            end
        end
        g.free_cnt   = COUNT_W'(free_tally);
        g.active_cnt = COUNT_W'(size_mark - free_tally);
        g.used_cnt   = COUNT_W'(size_mark);
        return g;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_grant got;
        t_grant want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.slot       = m_tdata[11:0];
                got.free_cnt   = m_tdata[24:12];
                got.active_cnt = m_tdata[37:25];
                got.used_cnt   = m_tdata[50:38];
                got.status     = m_tuser;
                if (awaited_grants.size() == 0) begin
                    $error("result word with nothing pending");
                    mismatch_count++;
                end else begin
                    want = awaited_grants.pop_front();
                    check_field("granted_slot", int'(want.slot), int'(got.slot));
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("free_slots", int'(want.free_cnt), int'(got.free_cnt));
                    check_field("active_slots", int'(want.active_cnt),
                                int'(got.active_cnt));
                    check_field("used_size", int'(want.used_cnt), int'(got.used_cnt));
                end
            end
            if (i_cfg_we)
                cap_reg = int'(i_cfg_wdata);
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser, s_tdata[SLOT_W-1:0]);
                if (word_typed)
                    want = word_ex;
                awaited_grants = {awaited_grants, want};
            end
        end
    end

    initial begin
        m_tready   = 1'b0;
        rx_holding = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_holding    = 1'b1;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_LEN; k++)
                    @(negedge i_clk);
                rx_holding = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] idx,
                             input bit typed, input t_grant ex);
        if (idle_on && !rx_holding && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= fn;
        s_tdata    <= {{(S_DATA_W - SLOT_W){1'b0}}, idx};
        word_typed <= typed;
        word_ex    <= ex;
        do
            @(posedge i_clk);
        while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (awaited_grants.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [FUNC_W-1:0] fn;
        logic [SLOT_W-1:0] idx;
        int                r;
        int                cap;

        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        word_typed     = 1'b0;
        word_ex        = '0;
        idle_on        = 1'b1;
        long_hold_req  = 1'b0;
        size_mark      = 0;
        free_tally     = 0;
        cap_reg        = 0;
        mismatch_count = 0;
        foreach (free_bits[i])
            free_bits[i] = 1'b0;

        add_row(typed_row(FN_QUERY,   0,    grant(0,    ST_DONE,     0, 0, 0)));
        add_row(typed_row(FN_UNDEF,   4095, grant(0,    ST_DONE,     0, 0, 0)));
        add_row(typed_row(FN_RELEASE, 0,    grant(0,    ST_BAD,      0, 0, 0)));
        add_row(typed_row(FN_RELEASE, 4095, grant(4095, ST_BAD,      0, 0, 0)));
        add_row(typed_row(FN_ALLOC,   0,    grant(0,    ST_APPENDED, 0, 1, 1)));
        add_row(typed_row(FN_ALLOC,   2730, grant(1,    ST_APPENDED, 0, 2, 2)));
        add_row(typed_row(FN_ALLOC,   4095, grant(2,    ST_APPENDED, 0, 3, 3)));
        add_row(typed_row(FN_RELEASE, 1,    grant(1,    ST_DONE,     1, 2, 3)));
        add_row(typed_row(FN_RELEASE, 1,    grant(1,    ST_DONE,     1, 2, 3)));
        add_row(typed_row(FN_RELEASE, 3,    grant(3,    ST_BAD,      1, 2, 3)));
        add_row(word_row(FN_RELEASE, 2));
        add_row(word_row(FN_RELEASE, 0));
        add_row(word_row(FN_ALLOC, 1365));
        add_row(word_row(FN_ALLOC, 0));
        add_row(cfg_row(2));
        add_row(typed_row(FN_ALLOC,   0,    grant(2,    ST_REUSED,   0, 3, 3)));
        add_row(typed_row(FN_ALLOC,   0,    grant(0,    ST_FULL,     0, 3, 3)));
        add_row(cfg_row(8191));
        add_row(typed_row(FN_ALLOC,   0,    grant(3,    ST_APPENDED, 0, 4, 4)));
        add_row(cfg_row(4));
        add_row(typed_row(FN_ALLOC,   0,    grant(0,    ST_FULL,     0, 4, 4)));
        add_row(word_row(FN_RELEASE, 3));
        add_row(word_row(FN_ALLOC, 0));
        add_row(cfg_row(1));
        add_row(typed_row(FN_QUERY,   0,    grant(0,    ST_DONE,     0, 4, 4)));
        add_row(cfg_row(4096));
        add_row(typed_row(FN_QUERY,   0,    grant(0,    ST_DONE,     0, 4, 4)));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                s_tvalid <= 1'b0;
                write_capacity(plan[i].cap);
            end else begin
                send_word(plan[i].fn, plan[i].idx, plan[i].typed, plan[i].ex);
            end
        end
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0: cap = 0;
                1: cap = 1;
                2: cap = 8191;
                3: cap = 4096;
                4: cap = size_mark + int'($urandom_range(0, 40));
                default: cap = int'($urandom_range(0, 8191));
            endcase
            write_capacity(CAP_W'(cap));
            idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (ph == 0) begin
                idle_on       = 1'b1;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                r = int'($urandom_range(0, 99));
                if (r < 45)
                    fn = FN_ALLOC;
                else if (r < 85)
                    fn = FN_RELEASE;
                else if (r < 95)
                    fn = FN_QUERY;
                else
                    fn = FN_UNDEF;
                if (fn == FN_RELEASE && r < 78 && size_mark != 0)
                    idx = SLOT_W'($urandom_range(0, size_mark - 1));
                else
                    idx = SLOT_W'($urandom_range(0, 4095));
                send_word(fn, idx, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
